// ===== design/lsfe_pkg.sv =====
// Package with shared types, constants and the sensor weighting function.
package lsfe_pkg;

  // Frame delimiters on the sensor link.
  localparam logic [7:0] FRAME_HEAD = 8'hFE;
  localparam logic [7:0] FRAME_TAIL = 8'hEF;

  localparam int unsigned SENSOR_W = 8;
  localparam int unsigned ERROR_W  = 7;

  // Signed weight of each sensor bit, bit 0 is the leftmost sensor.
  localparam logic signed [ERROR_W-1:0] BIT_WEIGHT [SENSOR_W] = '{
    -7'sd14, -7'sd10, -7'sd6, -7'sd3, 7'sd3, 7'sd6, 7'sd10, 7'sd14
  };

  // A completed frame handed from the parser to the error stage.
  typedef struct packed {
    logic                done;
    logic [SENSOR_W-1:0] bits;
  } frame_t;

  // One result word, first field in the highest bits.
  typedef struct packed {
    logic                       line_seen;
    logic                       err_usable;
    logic signed [ERROR_W-1:0]  line_error;
    logic [SENSOR_W-1:0]        sensor_bits;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // Sum of the weights of all set sensor bits; the result stays within -33..33.
  function automatic logic signed [ERROR_W-1:0] weigh_bits(input logic [SENSOR_W-1:0] bits);
    logic signed [ERROR_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < SENSOR_W; k++) begin
      if (bits[k]) begin
        sum = sum + BIT_WEIGHT[k];
      end
    end
    return sum;
  endfunction

endpackage

// ===== design/lsfe_frame.sv =====
// Frame parser: keeps up to two pending bytes and detects head, sensor, tail frames.
module lsfe_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           byte_i,
  output lsfe_pkg::frame_t     frame_o
);

  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [1:0] count_q, count_d;
  logic       done;

  // Pending byte update and frame detection for one accepted word.
  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    count_d  = count_q;
    done     = 1'b0;
    if (byte_valid_i) begin
      unique case (count_q)
        2'd0: begin
          first_d = byte_i;
          count_d = 2'd1;
        end
        2'd1: begin
          second_d = byte_i;
          count_d  = 2'd2;
        end
        default: begin
          priority if (first_q == lsfe_pkg::FRAME_HEAD && byte_i == lsfe_pkg::FRAME_TAIL) begin
            done    = 1'b1;
            count_d = 2'd0;
          end else if (second_q == lsfe_pkg::FRAME_HEAD) begin
            // Keep the trailing head byte and its follower as a new frame start.
            first_d  = second_q;
            second_d = byte_i;
            count_d  = 2'd2;
          end else if (byte_i == lsfe_pkg::FRAME_HEAD) begin
            first_d = lsfe_pkg::FRAME_HEAD;
            count_d = 2'd1;
          end else begin
            count_d = 2'd0;
          end
        end
      endcase
    end
  end

  assign frame_o.done = done;
  assign frame_o.bits = second_q;

  // Pending bytes and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      count_q  <= '0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/lsfe_eval.sv =====
// Line error stage: weights the sensor bits and holds the last valid error.
module lsfe_eval (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsfe_pkg::frame_t     frame_i,
  output lsfe_pkg::result_t    result_o
);

  logic signed [lsfe_pkg::ERROR_W-1:0] held_error_q, held_error_d;
  logic                                held_valid_q, held_valid_d;
  logic                                seen;

  assign seen = (frame_i.bits != '0);

  // Fresh error when a sensor is set, otherwise the held one or zero.
  always_comb begin
    held_error_d         = held_error_q;
    held_valid_d         = held_valid_q;
    result_o.sensor_bits = frame_i.bits;
    result_o.line_seen   = seen;
    if (seen) begin
      result_o.line_error = lsfe_pkg::weigh_bits(frame_i.bits);
      result_o.err_usable = 1'b1;
      if (frame_i.done) begin
        held_error_d = result_o.line_error;
        held_valid_d = 1'b1;
      end
    end else if (held_valid_q) begin
      result_o.line_error = held_error_q;
      result_o.err_usable = 1'b1;
    end else begin
      result_o.line_error = '0;
      result_o.err_usable = 1'b0;
    end
  end

  // Last valid error.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_error_q <= '0;
      held_valid_q <= 1'b0;
    end else begin
      held_error_q <= held_error_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

// ===== design/lsfe_out_fifo.sv =====
// Two-word result buffer that decouples the input side from output stalls.
module lsfe_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lsfe_pkg::result_t    push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output lsfe_pkg::result_t    data_o
);

  lsfe_pkg::result_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/line_sensor_frame_error_core.sv =====
// Line sensor frame decoder and weighted line error generator, top level.
// Throughput: one byte word per cycle while the output buffer is not full.
// A frame's result is pushed into the result buffer when its tail byte is taken.
// The two-word result buffer lets input continue while a result waits on the output.
// Reset (rst_ni low, asynchronous) clears pending bytes, the held error and the buffer.
module line_sensor_frame_error_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,   // [7:0] rx_byte
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [7:0] sensor_bits, [14:8] line_error, [15] err_usable, [16] line_seen, rest zero
  output logic [lsfe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  logic              in_accept;
  logic              fifo_full;
  lsfe_pkg::frame_t  frame;
  lsfe_pkg::result_t result;
  lsfe_pkg::result_t out_word;

  assign s_axis_tready_o = !fifo_full;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Frame search over the incoming bytes.
  lsfe_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept),
    .byte_i       (s_axis_tdata_i),
    .frame_o      (frame)
  );

  // Line error for each completed frame.
  lsfe_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame),
    .result_o (result)
  );

  // Result buffer toward the output side.
  lsfe_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (frame.done),
    .push_data_i (result),
    .full_o      (fifo_full),
    .valid_o     (m_axis_tvalid_o),
    .pop_i       (m_axis_tready_i),
    .data_o      (out_word)
  );

  assign m_axis_tdata_o = {{(lsfe_pkg::OUT_TDATA_W - lsfe_pkg::RESULT_W){1'b0}}, out_word};

endmodule

// ===== dv/tb_line_sensor_frame_error_core.sv =====
// Self-checking testbench for the line sensor frame decoder and line error core.
`timescale 1ns / 1ps

module tb_line_sensor_frame_error_core;

  localparam int CLK_PERIOD     = 10;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // Signed weight of each sensor bit, leftmost sensor first.
  localparam int SENSOR_WEIGHT [lsfe_pkg::SENSOR_W] = '{-14, -10, -6, -3, 3, 6, 10, 14};

  typedef enum logic [1:0] {
    RX_FULL,
    RX_CHOPPY,
    RX_SLOW
  } rx_mode_e;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [7:0]                       s_axis_tdata_i  = 8'h00;  // [7:0] rx_byte
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  // [7:0] sensor_bits, [14:8] line_error, [15] err_usable, [16] line_seen, rest zero
  logic [lsfe_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Bytes waiting to go out on the link, and the frame results they will produce.
  logic [7:0]        link_bytes [$];
  lsfe_pkg::result_t frame_results_q [$];

  // Predictor state: pending frame bytes and the last usable line error.
  logic [7:0]                          pend_lo  = '0;
  logic [7:0]                          pend_hi  = '0;
  logic [1:0]                          pend_cnt = '0;
  logic signed [lsfe_pkg::ERROR_W-1:0] held_err = '0;
  logic                                held_ok  = 1'b0;

  int fail_cnt   = 0;
  int hold_asked = 0;

  line_sensor_frame_error_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Weighted sum over the set sensor bits.
  function automatic logic signed [lsfe_pkg::ERROR_W-1:0] sum_sensor_weights(
    input logic [7:0] bits
  );
    int sum;
    sum = 0;
    for (int k = 0; k < lsfe_pkg::SENSOR_W; k++) begin
      if (bits[k]) begin
        sum += SENSOR_WEIGHT[k];
      end
    end
    return sum[lsfe_pkg::ERROR_W-1:0];
  endfunction

  // Advance the frame parser by one byte; report a result when a frame completes.
  function automatic void decode_rx_byte(input logic [7:0] rx, output logic made,
                                         output lsfe_pkg::result_t res);
    made = 1'b0;
    res  = '0;
    case (pend_cnt)
      2'd0: begin
        pend_lo  = rx;
        pend_cnt = 2'd1;
      end
      2'd1: begin
        pend_hi  = rx;
        pend_cnt = 2'd2;
      end
      default: begin
        if (pend_lo == lsfe_pkg::FRAME_HEAD && rx == lsfe_pkg::FRAME_TAIL) begin
          pend_cnt = 2'd0;
          made     = 1'b1;
          // A frame with no sensor set repeats the held error, if there is one.
          if (pend_hi != 8'h00) begin
            held_err = sum_sensor_weights(pend_hi);
            held_ok  = 1'b1;
          end
          res.sensor_bits = pend_hi;
          res.line_error  = held_ok ? held_err : '0;
          res.err_usable  = held_ok;
          res.line_seen   = (pend_hi != 8'h00);
        end else if (pend_hi == lsfe_pkg::FRAME_HEAD) begin
          // Keep a trailing head byte and the byte after it.
          pend_lo  = pend_hi;
          pend_hi  = rx;
          pend_cnt = 2'd2;
        end else if (rx == lsfe_pkg::FRAME_HEAD) begin
          pend_lo  = lsfe_pkg::FRAME_HEAD;
          pend_cnt = 2'd1;
        end else begin
          pend_cnt = 2'd0;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Driver: sends queued bytes in bursts with random gaps between them.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'h00;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (link_bytes.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= link_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: stalls in changing patterns, plus long hold-offs on request.
  int       hold_left  = 0;
  int       hold_taken = 0;
  int       mode_left  = 0;
  rx_mode_e rx_mode    = RX_FULL;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = LONG_HOLD;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FULL:   m_axis_tready_i <= 1'b1;
        RX_CHOPPY: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default:   m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: checks each result word, then predicts from each accepted input word.
  always @(posedge clk_i) begin : monitor
    lsfe_pkg::result_t got_res;
    lsfe_pkg::result_t exp_res;
    lsfe_pkg::result_t new_res;
    logic              made;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_res = lsfe_pkg::result_t'(m_axis_tdata_o[lsfe_pkg::RESULT_W-1:0]);
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h",
                   $time, m_axis_tdata_o);
          fail_cnt++;
        end else begin
          exp_res = frame_results_q.pop_front();
          check_field("sensor_bits", exp_res.sensor_bits, got_res.sensor_bits);
          check_field("line_error", $signed(exp_res.line_error), $signed(got_res.line_error));
          check_field("err_usable", exp_res.err_usable, got_res.err_usable);
          check_field("line_seen", exp_res.line_seen, got_res.line_seen);
          check_field("padding", 0, int'(m_axis_tdata_o >> lsfe_pkg::RESULT_W));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decode_rx_byte(s_axis_tdata_i, made, new_res);
        if (made) begin
          frame_results_q.push_back(new_res);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, frame_results_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_frame(input logic [7:0] bits);
    link_bytes.push_back(lsfe_pkg::FRAME_HEAD);
    link_bytes.push_back(bits);
    link_bytes.push_back(lsfe_pkg::FRAME_TAIL);
  endtask

  // Sensor bytes lean toward empty frames, single sensors and delimiter values.
  function automatic logic [7:0] pick_sensor_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2:       return 8'h01 << $urandom_range(0, 7);
      3:       return ($urandom_range(0, 1) != 0) ? lsfe_pkg::FRAME_HEAD : lsfe_pkg::FRAME_TAIL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly whole frames with random content, the rest broken frames and junk.
  task automatic queue_random_traffic(input int n_bytes);
    int start;
    int pick;
    start = link_bytes.size();
    while (link_bytes.size() - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        queue_frame(pick_sensor_byte());
      end else if (pick < 80) begin
        link_bytes.push_back(lsfe_pkg::FRAME_HEAD);
        link_bytes.push_back(pick_sensor_byte());
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) link_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        link_bytes.push_back(($urandom_range(0, 1) != 0) ? lsfe_pkg::FRAME_HEAD
                                                          : lsfe_pkg::FRAME_TAIL);
      end
    end
  endtask

  // Wait until the sender is empty and every expected result has come back.
  task automatic wait_drained();
    while (link_bytes.size() != 0 || s_axis_tvalid_i || frame_results_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty frame before any valid error, then the extremes and a held error.
    queue_frame(8'h00);
    queue_frame(8'h0F);
    queue_frame(8'hF0);
    queue_frame(8'hFF);
    queue_frame(8'h00);
    // Head byte in second place is kept with the byte after it.
    link_bytes.push_back(8'h12);
    link_bytes.push_back(lsfe_pkg::FRAME_HEAD);
    link_bytes.push_back(8'h81);
    link_bytes.push_back(lsfe_pkg::FRAME_TAIL);
    // Head byte arriving as the third byte starts a new frame.
    link_bytes.push_back(8'h12);
    link_bytes.push_back(8'h34);
    link_bytes.push_back(lsfe_pkg::FRAME_HEAD);
    link_bytes.push_back(8'h80);
    link_bytes.push_back(lsfe_pkg::FRAME_TAIL);
    // Three junk bytes are all dropped.
    link_bytes.push_back(8'h12);
    link_bytes.push_back(8'h34);
    link_bytes.push_back(8'h56);
    wait_drained();

    queue_random_traffic(350);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering bytes.
    @(negedge clk_i);
    hold_asked++;
    queue_random_traffic(300);
    wait_drained();

    queue_random_traffic(370);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
